// ===== src/bdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared codes, widths and the queue item type of the delta patch applier.
// ----------------------------------------------------------------------------
package bdp_pkg;

  localparam int LEN_W   = 23;
  localparam int IDX_W   = 22;
  localparam int WORD_W  = 64;
  localparam int Q_DEPTH = 4;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_CTRL  = 2'd1;
  localparam logic [1:0] OP_DIFF  = 2'd2;
  localparam logic [1:0] OP_EXTRA = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NEGATIVE   = 3'd1;
  localparam logic [2:0] ST_DIFF_OVER  = 3'd2;
  localparam logic [2:0] ST_EXTRA_OVER = 3'd3;
  localparam logic [2:0] ST_ORDER      = 3'd4;

  localparam logic REG_NEW_LENGTH  = 1'b0;
  localparam logic REG_BASE_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    Q_LOAD,
    Q_DIFF,
    Q_PASS
  } qkind_t;

  typedef struct packed {
    qkind_t             kind;
    logic               hit;
    logic [7:0]         data;
    logic [IDX_W-1:0]   index;
    logic               done;
    logic [2:0]         status;
  } qent_t;

endpackage
`default_nettype wire

// ===== src/bdp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdp_if
// Valid/ready channels for patch items and for patched output bytes.
// ----------------------------------------------------------------------------
interface bdp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [21:0] base_address;
  logic [7:0]  data_byte;
  logic [63:0] add_word;
  logic [63:0] copy_word;
  logic [63:0] seek_word;

  modport source (output valid, op, base_address, data_byte, add_word, copy_word,
                  seek_word, input ready);
  modport sink (input valid, op, base_address, data_byte, add_word, copy_word,
                seek_word, output ready);
endinterface

interface bdp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [21:0] out_index;
  logic        image_done;
  logic [2:0]  status;

  modport source (output valid, out_byte, out_index, image_done, status, input ready);
  modport sink (input valid, out_byte, out_index, image_done, status, output ready);
endinterface
`default_nettype wire

// ===== src/bdp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdp_front
// Accepts items, checks ordering and lengths, tracks the cursors and the
// sticky error, and queues one work item for each load or result.
// ----------------------------------------------------------------------------
module bdp_front
  import bdp_pkg::*;
#(
  parameter int BASE_DEPTH = 4194304,
  parameter int AW         = 22
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bdp_in_if.sink                in_if,
  input  wire logic [LEN_W-1:0] new_length,
  input  wire logic [LEN_W-1:0] base_length,
  output logic                  q_push,
  output qent_t                 q_ent,
  output logic [AW-1:0]         q_addr,
  input  wire logic             q_full
);

  logic [WORD_W-1:0] bc_r, bc_nxt;
  logic [LEN_W-1:0]  oc_r, oc_nxt;
  logic [LEN_W-1:0]  add_rem_r, add_rem_nxt;
  logic [LEN_W-1:0]  copy_rem_r, copy_rem_nxt;
  logic [WORD_W-1:0] pend_x_r, pend_x_nxt;
  logic              pend_c_r, pend_c_nxt;
  logic [2:0]        err_r, err_nxt;

  logic              acc;
  logic [24:0]       ld_a;
  logic              ld_hit;
  logic [24:0]       pos_lo;
  logic              rd_hit;
  logic              o_full;
  logic [LEN_W-1:0]  oc_inc;
  logic              done;
  logic [LEN_W-1:0]  rem;
  logic [LEN_W-1:0]  rem2;
  logic              neg_a;
  logic              neg_c;
  logic              add_big;
  logic              copy_big;
  logic [WORD_W-1:0] seek_x;
  logic              seek_c;
  logic [WORD_W-1:0] opnd;
  logic [1:0]        cin;
  logic              upd_bc;
  logic [WORD_W-1:0] bc_sum;
  logic [2:0]        code;

  assign in_if.ready = !q_full;
  assign acc         = in_if.valid && in_if.ready;

  assign ld_a     = 25'(in_if.base_address);
  assign ld_hit   = ld_a < 25'(BASE_DEPTH);
  assign pos_lo   = 25'(bc_r[LEN_W-1:0]);
  assign rd_hit   = (bc_r[WORD_W-1:LEN_W] == '0) && (bc_r[LEN_W-1:0] < base_length) &&
                    (pos_lo < 25'(BASE_DEPTH));
  assign o_full   = oc_r >= new_length;
  assign oc_inc   = oc_r + 23'd1;
  assign done     = oc_inc == new_length;
  assign rem      = new_length - oc_r;
  assign rem2     = rem - in_if.add_word[LEN_W-1:0];
  assign neg_a    = in_if.add_word[63] && (in_if.add_word[62:0] != '0);
  assign neg_c    = in_if.copy_word[63] && (in_if.copy_word[62:0] != '0);
  assign add_big  = (in_if.add_word[62:LEN_W] != '0) || (in_if.add_word[LEN_W-1:0] > rem);
  assign copy_big = (in_if.copy_word[62:LEN_W] != '0) ||
                    (in_if.copy_word[LEN_W-1:0] > rem2);
  assign seek_x   = in_if.seek_word[63] ? ~{1'b0, in_if.seek_word[62:0]}
                                        : {1'b0, in_if.seek_word[62:0]};
  assign seek_c   = in_if.seek_word[63];
  assign bc_sum   = bc_r + opnd + 64'(cin);
  assign bc_nxt   = upd_bc ? bc_sum : bc_r;

  always_comb begin
    oc_nxt       = oc_r;
    add_rem_nxt  = add_rem_r;
    copy_rem_nxt = copy_rem_r;
    pend_x_nxt   = pend_x_r;
    pend_c_nxt   = pend_c_r;
    err_nxt      = err_r;
    opnd         = '0;
    cin          = 2'd0;
    upd_bc       = 1'b0;
    code         = ST_OK;
    q_push       = 1'b0;
    q_addr       = pos_lo[AW-1:0];
    q_ent        = '{kind: Q_PASS, hit: 1'b0, data: 8'd0, index: oc_r[IDX_W-1:0],
                     done: 1'b0, status: err_r};
    if (acc) begin
      if (in_if.op == OP_LOAD) begin
        q_push     = 1'b1;
        q_ent.kind = Q_LOAD;
        q_ent.hit  = ld_hit;
        q_ent.data = in_if.data_byte;
        q_addr     = ld_a[AW-1:0];
      end else if (err_r != ST_OK) begin
        q_push = 1'b1;
      end else begin
        unique case (in_if.op)
          OP_CTRL: begin
            if ((add_rem_r != '0) || (copy_rem_r != '0) || o_full) begin
              code = ST_ORDER;
            end else if (neg_a || neg_c) begin
              code = ST_NEGATIVE;
            end else if (add_big) begin
              code = ST_DIFF_OVER;
            end else if (copy_big) begin
              code = ST_EXTRA_OVER;
            end else begin
              add_rem_nxt  = in_if.add_word[LEN_W-1:0];
              copy_rem_nxt = in_if.copy_word[LEN_W-1:0];
              if ((in_if.add_word[LEN_W-1:0] == '0) &&
                  (in_if.copy_word[LEN_W-1:0] == '0)) begin
                upd_bc     = 1'b1;
                opnd       = seek_x;
                cin        = {1'b0, seek_c};
                pend_x_nxt = '0;
                pend_c_nxt = 1'b0;
              end else begin
                pend_x_nxt = seek_x;
                pend_c_nxt = seek_c;
              end
            end
          end
          OP_DIFF: begin
            if (add_rem_r == '0) begin
              code = ST_ORDER;
            end else if (o_full) begin
              code = ST_DIFF_OVER;
            end else begin
              q_push       = 1'b1;
              q_ent.kind   = Q_DIFF;
              q_ent.hit    = rd_hit;
              q_ent.data   = in_if.data_byte;
              q_ent.done   = done;
              q_ent.status = ST_OK;
              oc_nxt       = oc_inc;
              add_rem_nxt  = add_rem_r - 23'd1;
              upd_bc       = 1'b1;
              cin          = 2'd1;
              if ((add_rem_r == 23'd1) && (copy_rem_r == '0)) begin
                opnd       = pend_x_r;
                cin        = 2'd1 + {1'b0, pend_c_r};
                pend_x_nxt = '0;
                pend_c_nxt = 1'b0;
              end
            end
          end
          default: begin
            if ((add_rem_r != '0) || (copy_rem_r == '0)) begin
              code = ST_ORDER;
            end else if (o_full) begin
              code = ST_EXTRA_OVER;
            end else begin
              q_push       = 1'b1;
              q_ent.data   = in_if.data_byte;
              q_ent.done   = done;
              q_ent.status = ST_OK;
              oc_nxt       = oc_inc;
              copy_rem_nxt = copy_rem_r - 23'd1;
              if (copy_rem_r == 23'd1) begin
                upd_bc     = 1'b1;
                opnd       = pend_x_r;
                cin        = {1'b0, pend_c_r};
                pend_x_nxt = '0;
                pend_c_nxt = 1'b0;
              end
            end
          end
        endcase
        if (code != ST_OK) begin
          q_push       = 1'b1;
          q_ent.status = code;
          err_nxt      = code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r       <= '0;
      oc_r       <= '0;
      add_rem_r  <= '0;
      copy_rem_r <= '0;
      pend_x_r   <= '0;
      pend_c_r   <= 1'b0;
      err_r      <= ST_OK;
    end else begin
      bc_r       <= bc_nxt;
      oc_r       <= oc_nxt;
      add_rem_r  <= add_rem_nxt;
      copy_rem_r <= copy_rem_nxt;
      pend_x_r   <= pend_x_nxt;
      pend_c_r   <= pend_c_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/bdp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdp_fifo
// Short queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module bdp_fifo
  import bdp_pkg::*;
#(
  parameter int AW = 22
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire qent_t         push_ent,
  input  wire logic [AW-1:0] push_addr,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output qent_t              head_ent,
  output logic [AW-1:0]      head_addr
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  qent_t         ent_r  [Q_DEPTH];
  logic [AW-1:0] addr_r [Q_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == CW'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_ent   = ent_r[rp_r];
  assign head_addr  = addr_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(Q_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(Q_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r]  <= push_ent;
      addr_r[wp_r] <= push_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/bdp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdp_back
// Holds the base image memory, applies loads, reads base bytes for diff
// items, forms the patched byte and drives the output register.
// ----------------------------------------------------------------------------
module bdp_back
  import bdp_pkg::*;
#(
  parameter int BASE_DEPTH = 4194304,
  parameter int AW         = 22
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire qent_t         head_ent,
  input  wire logic [AW-1:0] head_addr,
  output logic               pop,
  bdp_out_if.source          out_if
);

  logic [7:0]       mem [BASE_DEPTH];
  logic [7:0]       rdata_r;
  qent_t            s1_r;
  logic             s1_v_r, s1_v_nxt;
  logic             out_v_r, out_v_nxt;
  logic [7:0]       byte_r;
  logic [IDX_W-1:0] index_r;
  logic             done_r;
  logic [2:0]       status_r;
  logic             s1_adv;
  logic             head_ld;
  logic [7:0]       s1_byte;

  assign head_ld   = head_ent.kind == Q_LOAD;
  assign s1_adv    = s1_v_r && (!out_v_r || out_if.ready);
  assign pop       = head_valid && (head_ld || !s1_v_r || s1_adv);
  assign s1_v_nxt  = (pop && !head_ld) || (s1_v_r && !s1_adv);
  assign out_v_nxt = s1_adv || (out_v_r && !out_if.ready);
  assign s1_byte   = (s1_r.kind == Q_DIFF) ? ((s1_r.hit ? rdata_r : 8'd0) + s1_r.data)
                                           : s1_r.data;

  always_ff @(posedge clk) begin
    if (pop && head_ld && head_ent.hit) begin
      mem[head_addr] <= head_ent.data;
    end
    if (pop && !head_ld) begin
      rdata_r <= mem[head_addr];
      s1_r    <= head_ent;
    end
    if (s1_adv) begin
      byte_r   <= s1_byte;
      index_r  <= s1_r.index;
      done_r   <= s1_r.done;
      status_r <= s1_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.out_byte   = byte_r;
  assign out_if.out_index  = index_r;
  assign out_if.image_done = done_r;
  assign out_if.status     = status_r;

endmodule
`default_nettype wire

// ===== src/binary_delta_patch_applier_unit.sv =====
`default_nettype none
// Path: a result item passes the queue, the read stage register and the output
// register, when nothing waits ahead of it.
// Throughput: one item per cycle unless the queue fills or the output stalls; each
// non-load item reads the single base memory port, and loads write through it.
// Reset: synchronous active low; clears cursors, lengths, the error status,
// the queue and the output register. The base memory is not cleared.
// ----------------------------------------------------------------------------
// binary_delta_patch_applier_unit
// Streaming applier for a binary delta: base loads, control triples, diff
// and extra bytes, with a sticky error status.
// ----------------------------------------------------------------------------
module binary_delta_patch_applier_unit
  import bdp_pkg::*;
#(
  parameter int BASE_DEPTH = 4194304
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bdp_in_if.sink                in_if,
  bdp_out_if.source             out_if,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [LEN_W-1:0] cfg_data
);

  localparam int AW = $clog2(BASE_DEPTH);

  logic [LEN_W-1:0] new_length_r;
  logic [LEN_W-1:0] base_length_r;
  logic             q_push;
  qent_t            q_ent;
  logic [AW-1:0]    q_addr;
  logic             q_full;
  logic             q_pop;
  logic             head_valid;
  qent_t            head_ent;
  logic [AW-1:0]    head_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_length_r  <= '0;
      base_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEW_LENGTH:  new_length_r  <= cfg_data;
        REG_BASE_LENGTH: base_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bdp_front #(
    .BASE_DEPTH(BASE_DEPTH),
    .AW        (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .new_length (new_length_r),
    .base_length(base_length_r),
    .q_push     (q_push),
    .q_ent      (q_ent),
    .q_addr     (q_addr),
    .q_full     (q_full)
  );

  bdp_fifo #(
    .AW(AW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ent  (q_ent),
    .push_addr (q_addr),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(head_valid),
    .head_ent  (head_ent),
    .head_addr (head_addr)
  );

  bdp_back #(
    .BASE_DEPTH(BASE_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_ent  (head_ent),
    .head_addr (head_addr),
    .pop       (q_pop),
    .out_if    (out_if)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("work item queued while the queue is full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> head_valid)
    else $error("work item taken from an empty queue");

  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready == !q_full)
    else $error("input ready does not follow queue space");
`endif

endmodule
`default_nettype wire
